FILE: src/utfd_pkg.sv
// Shared types and constants for the UTF byte stream decoder.
// Used by utfd_step_core, utfd_out_buf and utf_byte_stream_decoder; no dependencies.
package utfd_pkg;

    // Encoding selected by the configuration register.
    typedef enum logic [1:0] {
        MODE_UTF8     = 2'd0,
        MODE_UTF16BE  = 2'd1,
        MODE_UTF16LE  = 2'd2,
        MODE_RESERVED = 2'd3
    } mode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_INVALID   = 2'd1,
        STATUS_TRUNCATED = 2'd2,
        STATUS_SURROGATE = 2'd3
    } status_t;

    localparam int CP_W = 21;

    // UTF-8 lead and continuation byte patterns.
    localparam logic [7:0] UTF8_LEAD2_MASK = 8'b1110_0000;
    localparam logic [7:0] UTF8_LEAD2_TAG  = 8'b1100_0000;
    localparam logic [7:0] UTF8_LEAD3_MASK = 8'b1111_0000;
    localparam logic [7:0] UTF8_LEAD3_TAG  = 8'b1110_0000;
    localparam logic [7:0] UTF8_LEAD4_MASK = 8'b1111_1000;
    localparam logic [7:0] UTF8_LEAD4_TAG  = 8'b1111_0000;
    localparam logic [7:0] UTF8_CONT_MASK  = 8'b1100_0000;
    localparam logic [7:0] UTF8_CONT_TAG   = 8'b1000_0000;
    localparam logic [7:0] UTF8_LEAD2_MIN  = 8'hC2;
    localparam logic [7:0] UTF8_LEAD4_MAX  = 8'hF4;
    localparam logic [7:0] UTF8_CONT_LO    = 8'h80;
    localparam logic [7:0] UTF8_CONT_HI    = 8'hBF;
    localparam logic [7:0] UTF8_E0         = 8'hE0;
    localparam logic [7:0] UTF8_ED         = 8'hED;
    localparam logic [7:0] UTF8_F0         = 8'hF0;
    localparam logic [7:0] UTF8_F4         = 8'hF4;
    localparam logic [7:0] UTF8_E0_LO      = 8'hA0;
    localparam logic [7:0] UTF8_ED_HI      = 8'h9F;
    localparam logic [7:0] UTF8_F0_LO      = 8'h90;
    localparam logic [7:0] UTF8_F4_HI      = 8'h8F;

    // UTF-16 surrogate tags on the top six bits of a code unit.
    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

    // One decoded result.
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        status_t         status;
    } result_t;

    // Decoding state carried between bytes.
    typedef struct packed {
        logic [CP_W-1:0] partial_value;
        logic [1:0]      bytes_pending;
        logic [7:0]      held_byte;
        logic            odd_byte_phase;
        logic            high_surrogate_seen;
    } dec_state_t;

endpackage

FILE: src/utfd_step_core.sv
// Per-byte decode step: state registers, mode register and the next-state logic.
// Depends on utfd_pkg.
module utfd_step_core
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_data,
    input  logic                   in_valid,
    input  logic [7:0]             in_byte,
    input  logic                   in_last,
    output logic                   res_valid,
    output utfd_pkg::result_t      res
);

    utfd_pkg::mode_t      mode_reg;
    utfd_pkg::dec_state_t st_reg;
    utfd_pkg::dec_state_t st_next;
    logic                 res_has;

    // Next state and result for the byte on the input.
    always_comb
    begin
        logic [15:0]       unit;
        logic [7:0]        lo;
        logic [7:0]        hi;
        utfd_pkg::status_t bad;
        logic              busy;

        st_next        = st_reg;
        res_has        = 1'b0;
        res.code_point = '0;
        res.status     = utfd_pkg::STATUS_OK;
        unit           = '0;
        lo             = utfd_pkg::UTF8_CONT_LO;
        hi             = utfd_pkg::UTF8_CONT_HI;
        bad            = utfd_pkg::STATUS_INVALID;

        unique case (mode_reg)
            utfd_pkg::MODE_UTF8:
            begin
                if (st_reg.bytes_pending == 2'd0)
                begin
                    // Lead byte.
                    if (!in_byte[7])
                    begin
                        res_has        = 1'b1;
                        res.code_point = {13'd0, in_byte};
                    end
                    else if ((in_byte & utfd_pkg::UTF8_LEAD2_MASK) == utfd_pkg::UTF8_LEAD2_TAG
                             && in_byte >= utfd_pkg::UTF8_LEAD2_MIN)
                    begin
                        st_next.partial_value = {16'd0, in_byte[4:0]};
                        st_next.bytes_pending = 2'd1;
                        st_next.held_byte     = in_byte;
                    end
                    else if ((in_byte & utfd_pkg::UTF8_LEAD3_MASK) == utfd_pkg::UTF8_LEAD3_TAG)
                    begin
                        st_next.partial_value = {17'd0, in_byte[3:0]};
                        st_next.bytes_pending = 2'd2;
                        st_next.held_byte     = in_byte;
                    end
                    else if ((in_byte & utfd_pkg::UTF8_LEAD4_MASK) == utfd_pkg::UTF8_LEAD4_TAG
                             && in_byte <= utfd_pkg::UTF8_LEAD4_MAX)
                    begin
                        st_next.partial_value = {18'd0, in_byte[2:0]};
                        st_next.bytes_pending = 2'd3;
                        st_next.held_byte     = in_byte;
                    end
                    else
                    begin
                        res_has    = 1'b1;
                        res.status = utfd_pkg::STATUS_INVALID;
                        st_next    = '0;
                    end
                end
                else
                begin
                    // Continuation byte; the first one after some leads has a narrower range.
                    if (st_reg.bytes_pending == 2'd2 && st_reg.held_byte == utfd_pkg::UTF8_E0)
                        lo = utfd_pkg::UTF8_E0_LO;
                    if (st_reg.bytes_pending == 2'd2 && st_reg.held_byte == utfd_pkg::UTF8_ED)
                    begin
                        hi  = utfd_pkg::UTF8_ED_HI;
                        bad = utfd_pkg::STATUS_SURROGATE;
                    end
                    if (st_reg.bytes_pending == 2'd3 && st_reg.held_byte == utfd_pkg::UTF8_F0)
                        lo = utfd_pkg::UTF8_F0_LO;
                    if (st_reg.bytes_pending == 2'd3 && st_reg.held_byte == utfd_pkg::UTF8_F4)
                        hi = utfd_pkg::UTF8_F4_HI;

                    if ((in_byte & utfd_pkg::UTF8_CONT_MASK) != utfd_pkg::UTF8_CONT_TAG)
                    begin
                        res_has    = 1'b1;
                        res.status = utfd_pkg::STATUS_INVALID;
                        st_next    = '0;
                    end
                    else if (in_byte < lo || in_byte > hi)
                    begin
                        res_has    = 1'b1;
                        res.status = bad;
                        st_next    = '0;
                    end
                    else if (st_reg.bytes_pending == 2'd1)
                    begin
                        res_has        = 1'b1;
                        res.code_point = {st_reg.partial_value[14:0], in_byte[5:0]};
                        st_next        = '0;
                    end
                    else
                    begin
                        st_next.partial_value = {st_reg.partial_value[14:0], in_byte[5:0]};
                        st_next.bytes_pending = st_reg.bytes_pending - 2'd1;
                    end
                end
            end

            utfd_pkg::MODE_UTF16BE,
            utfd_pkg::MODE_UTF16LE:
            begin
                if (!st_reg.odd_byte_phase)
                begin
                    // First byte of a code unit is held.
                    st_next.held_byte      = in_byte;
                    st_next.odd_byte_phase = 1'b1;
                end
                else
                begin
                    if (mode_reg == utfd_pkg::MODE_UTF16BE)
                        unit = {st_reg.held_byte, in_byte};
                    else
                        unit = {in_byte, st_reg.held_byte};
                    st_next.odd_byte_phase = 1'b0;
                    st_next.held_byte      = '0;

                    if (st_reg.high_surrogate_seen)
                    begin
                        res_has = 1'b1;
                        if (unit[15:10] == utfd_pkg::SURR_LOW_TAG)
                            res.code_point = utfd_pkg::SUPP_BASE
                                + {1'b0, st_reg.partial_value[9:0], unit[9:0]};
                        else
                            res.status = utfd_pkg::STATUS_SURROGATE;
                        st_next = '0;
                    end
                    else if (unit[15:10] == utfd_pkg::SURR_HIGH_TAG)
                    begin
                        st_next.partial_value       = {11'd0, unit[9:0]};
                        st_next.high_surrogate_seen = 1'b1;
                    end
                    else if (unit[15:10] == utfd_pkg::SURR_LOW_TAG)
                    begin
                        res_has    = 1'b1;
                        res.status = utfd_pkg::STATUS_SURROGATE;
                        st_next    = '0;
                    end
                    else
                    begin
                        res_has        = 1'b1;
                        res.code_point = {5'd0, unit};
                    end
                end
            end

            utfd_pkg::MODE_RESERVED:
            begin
                res_has    = 1'b1;
                res.status = utfd_pkg::STATUS_INVALID;
                st_next    = '0;
            end

            default:
            begin
                res_has    = 1'b1;
                res.status = utfd_pkg::STATUS_INVALID;
                st_next    = '0;
            end
        endcase

        // End of stream: report a cut-off sequence and drop all state.
        busy = st_next.bytes_pending != 2'd0 || st_next.odd_byte_phase
               || st_next.high_surrogate_seen;
        if (in_last)
        begin
            if (!res_has && busy)
            begin
                res_has        = 1'b1;
                res.code_point = '0;
                res.status     = utfd_pkg::STATUS_TRUNCATED;
            end
            st_next = '0;
        end
    end

    assign res_valid = in_valid && res_has;

    // Mode and decoding state; a mode write restarts decoding.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= utfd_pkg::MODE_UTF8;
            st_reg   <= '0;
        end
        else if (cfg_we)
        begin
            mode_reg <= utfd_pkg::mode_t'(cfg_data);
            st_reg   <= '0;
        end
        else if (in_valid)
        begin
            st_reg <= st_next;
        end
    end

`ifndef SYNTHESIS
    // The last byte of a stream leaves no decoding state behind.
    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_last |=> st_reg == '0)
        else $error("decoding state not cleared after end of stream");

    // Every error resynchronizes the decoder.
    a_error_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status != utfd_pkg::STATUS_OK |=> st_reg == '0)
        else $error("decoding state not cleared after an error");

    // A good result is a Unicode scalar value.
    a_scalar_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == utfd_pkg::STATUS_OK
        |-> res.code_point <= 21'h10FFFF
            && (res.code_point < 21'hD800 || res.code_point > 21'hDFFF))
        else $error("decoded value outside the scalar range");

    // UTF-8 continuation count is only used in UTF-8 mode.
    a_pending_mode: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != utfd_pkg::MODE_UTF8 |-> st_reg.bytes_pending == 2'd0)
        else $error("continuation count set outside UTF-8 mode");
`endif

endmodule

FILE: src/utfd_out_buf.sv
// Output register with a skid stage for decoded results.
// Depends on utfd_pkg.
module utfd_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    input  utfd_pkg::result_t wr_data,
    output logic              wr_ready,
    output logic              rd_valid,
    output utfd_pkg::result_t rd_data,
    input  logic              rd_ready
);

    logic              out_valid_reg;
    utfd_pkg::result_t out_data_reg;
    logic              skid_valid_reg;
    utfd_pkg::result_t skid_data_reg;

    // Space is free while the skid stage is empty.
    assign wr_ready = !skid_valid_reg;
    assign rd_valid = out_valid_reg;
    assign rd_data  = out_data_reg;

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || rd_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= wr_valid;
            end
        end
        else if (wr_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || rd_ready)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (wr_valid)
                out_data_reg <= wr_data;
        end
        else if (wr_valid)
        begin
            skid_data_reg <= wr_data;
        end
    end

endmodule

FILE: src/utf_byte_stream_decoder.sv
// UTF-8 / UTF-16 byte stream decoder, top level.
// Depends on utfd_pkg, utfd_step_core and utfd_out_buf.
//
// The decoder takes one byte per beat on the slave side and returns Unicode scalar
// values on the master side, one beat per completed character or detected error.
// Each byte is decoded by combinational step logic, so a byte can be accepted on
// every clock while s_tready is high; its result goes to the master side from the
// output register, loaded directly while free. A skid stage behind that register lets
// one more result in while the downstream side stalls; s_tready drops only when both
// are full. The encoding is set through the cfg channel (0 UTF-8, 1 UTF-16 BE,
// 2 UTF-16 LE; 3 flags every byte invalid); a write restarts decoding and must be
// done while no beat is in flight. m_tuser carries the status: 0 ok, 1 invalid byte,
// 2 truncated sequence, 3 surrogate error; m_tdata is zero on any error.
module utf_byte_stream_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,     // encoding_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] data_byte
    input  logic        s_tlast,      // end_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,      // [20:0] code_point, [23:21] zero
    output logic [1:0]  m_tuser       // [1:0] status
);

    logic              in_accept;
    logic              res_valid;
    utfd_pkg::result_t res;
    utfd_pkg::result_t out_res;

    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;

    // Decode step.
    utfd_step_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .in_valid  (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register and skid stage.
    utfd_out_buf u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (res_valid),
        .wr_data  (res),
        .wr_ready (s_tready),
        .rd_valid (m_tvalid),
        .rd_data  (out_res),
        .rd_ready (m_tready)
    );

    assign m_tdata = {3'd0, out_res.code_point};
    assign m_tuser = out_res.status;

endmodule

FILE: sim/utfd_stream_checker.sv
`timescale 1ns / 1ps
// Stream checker for the UTF byte stream decoder: follows the encoding register,
// predicts the result of every accepted input beat and compares it with the output beats.
// Depends on utfd_pkg.
module utfd_stream_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,      // [20:0] code_point, [23:21] zero
    input  logic [1:0]  m_tuser,      // [1:0] status
    output int          mismatches,
    output int          outstanding
);

    utfd_pkg::mode_t      enc_mode = utfd_pkg::MODE_UTF8;
    utfd_pkg::dec_state_t dec = '0;
    utfd_pkg::result_t    decoded_q[$];

    initial
    begin
        mismatches = 0;
        outstanding = 0;
    end

    // Decodes one byte against the tracked state; got is set when a result is due.
    task automatic decode_byte(input logic [7:0] b, input logic eos,
                               output bit got, output utfd_pkg::result_t res);
        logic [7:0]        lo;
        logic [7:0]        hi;
        utfd_pkg::status_t cont_err;
        logic [15:0]       unit;
        bit                busy;
        got = 1'b0;
        res = '0;
        res.status = utfd_pkg::STATUS_OK;
        case (enc_mode)
            utfd_pkg::MODE_UTF8:
            begin
                if (dec.bytes_pending == 2'd0)
                begin
                    // A lead byte either completes ASCII, opens a sequence or is invalid.
                    if (b < 8'h80)
                    begin
                        got = 1'b1;
                        res.code_point = {13'd0, b};
                    end
                    else if ((b & utfd_pkg::UTF8_LEAD2_MASK) == utfd_pkg::UTF8_LEAD2_TAG
                             && b >= utfd_pkg::UTF8_LEAD2_MIN)
                    begin
                        dec.partial_value = {16'd0, b[4:0]};
                        dec.bytes_pending = 2'd1;
                        dec.held_byte = b;
                    end
                    else if ((b & utfd_pkg::UTF8_LEAD3_MASK) == utfd_pkg::UTF8_LEAD3_TAG)
                    begin
                        dec.partial_value = {17'd0, b[3:0]};
                        dec.bytes_pending = 2'd2;
                        dec.held_byte = b;
                    end
                    else if ((b & utfd_pkg::UTF8_LEAD4_MASK) == utfd_pkg::UTF8_LEAD4_TAG
                             && b <= utfd_pkg::UTF8_LEAD4_MAX)
                    begin
                        dec.partial_value = {18'd0, b[2:0]};
                        dec.bytes_pending = 2'd3;
                        dec.held_byte = b;
                    end
                    else
                    begin
                        got = 1'b1;
                        res.status = utfd_pkg::STATUS_INVALID;
                    end
                end
                else
                begin
                    // The first continuation after some leads has a narrowed range.
                    lo = utfd_pkg::UTF8_CONT_LO;
                    hi = utfd_pkg::UTF8_CONT_HI;
                    cont_err = utfd_pkg::STATUS_INVALID;
                    if (dec.bytes_pending == 2'd2 && dec.held_byte == utfd_pkg::UTF8_E0)
                        lo = utfd_pkg::UTF8_E0_LO;
                    if (dec.bytes_pending == 2'd2 && dec.held_byte == utfd_pkg::UTF8_ED)
                    begin
                        hi = utfd_pkg::UTF8_ED_HI;
                        cont_err = utfd_pkg::STATUS_SURROGATE;
                    end
                    if (dec.bytes_pending == 2'd3 && dec.held_byte == utfd_pkg::UTF8_F0)
                        lo = utfd_pkg::UTF8_F0_LO;
                    if (dec.bytes_pending == 2'd3 && dec.held_byte == utfd_pkg::UTF8_F4)
                        hi = utfd_pkg::UTF8_F4_HI;
                    if ((b & utfd_pkg::UTF8_CONT_MASK) != utfd_pkg::UTF8_CONT_TAG)
                    begin
                        got = 1'b1;
                        res.status = utfd_pkg::STATUS_INVALID;
                    end
                    else if (b < lo || b > hi)
                    begin
                        got = 1'b1;
                        res.status = cont_err;
                    end
                    else
                    begin
                        dec.partial_value = {dec.partial_value[14:0], b[5:0]};
                        dec.bytes_pending = dec.bytes_pending - 2'd1;
                        if (dec.bytes_pending == 2'd0)
                        begin
                            got = 1'b1;
                            res.code_point = dec.partial_value;
                            dec = '0;
                        end
                    end
                end
            end
            utfd_pkg::MODE_UTF16BE, utfd_pkg::MODE_UTF16LE:
            begin
                if (!dec.odd_byte_phase)
                begin
                    dec.held_byte = b;
                    dec.odd_byte_phase = 1'b1;
                end
                else
                begin
                    unit = (enc_mode == utfd_pkg::MODE_UTF16BE) ? {dec.held_byte, b}
                                                                : {b, dec.held_byte};
                    dec.odd_byte_phase = 1'b0;
                    dec.held_byte = '0;
                    if (dec.high_surrogate_seen)
                    begin
                        // A waiting high surrogate needs a low one, else the pair is broken.
                        got = 1'b1;
                        if (unit[15:10] == utfd_pkg::SURR_LOW_TAG)
                        begin
                            res.code_point = utfd_pkg::SUPP_BASE
                                + {1'b0, dec.partial_value[9:0], unit[9:0]};
                            dec = '0;
                        end
                        else
                            res.status = utfd_pkg::STATUS_SURROGATE;
                    end
                    else if (unit[15:10] == utfd_pkg::SURR_HIGH_TAG)
                    begin
                        dec.partial_value = {11'd0, unit[9:0]};
                        dec.high_surrogate_seen = 1'b1;
                    end
                    else
                    begin
                        got = 1'b1;
                        if (unit[15:10] == utfd_pkg::SURR_LOW_TAG)
                            res.status = utfd_pkg::STATUS_SURROGATE;
                        else
                            res.code_point = {5'd0, unit};
                    end
                end
            end
            default:
            begin
                got = 1'b1;
                res.status = utfd_pkg::STATUS_INVALID;
            end
        endcase
        // Errors carry no code point and drop the sequence in progress.
        if (got && res.status != utfd_pkg::STATUS_OK)
        begin
            res.code_point = '0;
            dec = '0;
        end
        // End of stream inside a sequence reports truncation; the state is cleared anyway.
        if (eos)
        begin
            busy = dec.bytes_pending != 2'd0 || dec.odd_byte_phase || dec.high_surrogate_seen;
            if (!got && busy)
            begin
                got = 1'b1;
                res.code_point = '0;
                res.status = utfd_pkg::STATUS_TRUNCATED;
            end
            dec = '0;
        end
    endtask

    // Output beats are checked before the input beat of the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        utfd_pkg::result_t want;
        utfd_pkg::result_t next_res;
        bit                next_got;
        if (!rst_n)
        begin
            enc_mode = utfd_pkg::MODE_UTF8;
            dec = '0;
            decoded_q.delete();
            mismatches = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected output beat: code_point %h status %0d",
                           m_tdata[20:0], m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (m_tdata[20:0] !== want.code_point)
                    begin
                        $error("code_point: expected %h, actual %h", want.code_point,
                               m_tdata[20:0]);
                        mismatches++;
                    end
                    if (m_tdata[23:21] !== 3'b000)
                    begin
                        $error("tdata padding: expected 0, actual %b", m_tdata[23:21]);
                        mismatches++;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                enc_mode = utfd_pkg::mode_t'(cfg_data);
                dec = '0;
            end
            if (s_tvalid && s_tready)
            begin
                decode_byte(s_tdata, s_tlast, next_got, next_res);
                if (next_got)
                    decoded_q.push_back(next_res);
            end
        end
        outstanding = decoded_q.size();
    end

endmodule

FILE: sim/utf_byte_stream_decoder_tb.sv
`timescale 1ns / 1ps
// Top of the UTF byte stream decoder testbench: clock, reset, byte stimulus, receiver
// stalls, watchdog and verdict. Depends on utfd_pkg, utfd_stream_checker and the decoder.
module utf_byte_stream_decoder_tb;

    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int BLOCK_BEATS    = 100;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tready = 1'b0;
    wire         cfg_ready;
    wire         s_tready;
    wire         m_tvalid;
    wire  [23:0] m_tdata;
    wire  [1:0]  m_tuser;

    int              mismatches;
    int              outstanding;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              beats_sent = 0;
    int              quiet_cycles = 0;
    bit              hold_req = 1'b0;
    utfd_pkg::mode_t cur_mode = utfd_pkg::MODE_UTF8;

    always #10 clk = ~clk;

    utf_byte_stream_decoder uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    utfd_stream_checker stream_chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Receiver: random stalls, or one long hold-off when the stimulus asks for it.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles in which no channel moves a beat.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic rand_last();
        return ($urandom_range(99) < 3);
    endfunction

    // Offers one byte, with a random idle gap in front, and returns after its beat.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge clk); while (!s_tready);
        beats_sent++;
        @(negedge clk);
    endtask

    // Writes the encoding once every expected result is out and the pipe has settled.
    task automatic write_mode(input utfd_pkg::mode_t mode);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_mode = mode;
    endtask

    task automatic send_utf8_cp(input logic [20:0] cp);
        if (cp < 21'h80)
            send_byte(cp[7:0], rand_last());
        else if (cp < 21'h800)
        begin
            send_byte({3'b110, cp[10:6]}, rand_last());
            send_byte({2'b10, cp[5:0]}, rand_last());
        end
        else if (cp < 21'h10000)
        begin
            send_byte({4'b1110, cp[15:12]}, rand_last());
            send_byte({2'b10, cp[11:6]}, rand_last());
            send_byte({2'b10, cp[5:0]}, rand_last());
        end
        else
        begin
            send_byte({5'b11110, cp[20:18]}, rand_last());
            send_byte({2'b10, cp[17:12]}, rand_last());
            send_byte({2'b10, cp[11:6]}, rand_last());
            send_byte({2'b10, cp[5:0]}, rand_last());
        end
    endtask

    // Mostly well-formed characters, mixed with noise bytes and broken sequences.
    task automatic send_utf8_random();
        int          kind;
        int          tail;
        logic [20:0] cp;
        logic [7:0]  lead;
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            case ($urandom_range(3))
                0: cp = 21'($urandom_range(21'h7F));
                1: cp = 21'($urandom_range(21'h7FF, 21'h80));
                2: cp = 21'($urandom_range(21'hFFFF, 21'h800));
                default: cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
            endcase
            send_utf8_cp(cp);
        end
        else if (kind < 85)
            send_byte(8'($urandom_range(255)), rand_last());
        else
        begin
            case ($urandom_range(4))
                0: lead = utfd_pkg::UTF8_E0;
                1: lead = utfd_pkg::UTF8_ED;
                2: lead = utfd_pkg::UTF8_F0;
                3: lead = utfd_pkg::UTF8_F4;
                default: lead = 8'($urandom_range(8'hF4, 8'hC2));
            endcase
            send_byte(lead, rand_last());
            tail = $urandom_range(3, 1);
            repeat (tail)
            begin
                if ($urandom_range(3) != 0)
                    send_byte(8'($urandom_range(8'hBF, 8'h80)), rand_last());
                else
                    send_byte(8'($urandom_range(255)), rand_last());
            end
        end
    endtask

    task automatic send_unit(input logic [15:0] unit);
        if (cur_mode == utfd_pkg::MODE_UTF16BE)
        begin
            send_byte(unit[15:8], rand_last());
            send_byte(unit[7:0], rand_last());
        end
        else
        begin
            send_byte(unit[7:0], rand_last());
            send_byte(unit[15:8], rand_last());
        end
    endtask

    // Plain units and surrogate pairs, with lone surrogates and odd single bytes.
    task automatic send_utf16_random();
        int kind;
        kind = $urandom_range(99);
        if (kind < 55)
            send_unit(16'($urandom_range(16'hFFFF)));
        else if (kind < 80)
        begin
            send_unit({utfd_pkg::SURR_HIGH_TAG, 10'($urandom_range(10'h3FF))});
            send_unit({utfd_pkg::SURR_LOW_TAG, 10'($urandom_range(10'h3FF))});
        end
        else if (kind < 90)
            send_unit({5'b11011, 11'($urandom_range(11'h7FF))});
        else
            send_byte(8'($urandom_range(255)), rand_last());
    endtask

    task automatic run_random(input int beats);
        int target;
        target = beats_sent + beats;
        while (beats_sent < target)
        begin
            case (cur_mode)
                utfd_pkg::MODE_UTF8: send_utf8_random();
                utfd_pkg::MODE_UTF16BE, utfd_pkg::MODE_UTF16LE: send_utf16_random();
                default: send_byte(8'($urandom_range(255)), rand_last());
            endcase
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // UTF-8 after reset: ASCII extremes, range ends, bad leads and continuations,
        // narrowed ranges, an encoded surrogate and a sequence cut by end of stream.
        send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b0);
        send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hE0, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
        send_byte(8'h80, 1'b0); send_byte(8'hFF, 1'b0);
        send_byte(8'hE0, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0);
        send_byte(8'hF4, 1'b0); send_byte(8'h90, 1'b0);
        send_byte(8'hC2, 1'b0); send_byte(8'h41, 1'b0);
        send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);

        // UTF-16 BE: a pair, a lone low surrogate, a broken pair, an odd final byte.
        write_mode(utfd_pkg::MODE_UTF16BE);
        send_byte(8'hD8, 1'b0); send_byte(8'h3D, 1'b0);
        send_byte(8'hDE, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'hDC, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'hD8, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0); send_byte(8'h41, 1'b0);
        send_byte(8'hFF, 1'b1);

        // UTF-16 LE: a high surrogate left waiting at end of stream.
        write_mode(utfd_pkg::MODE_UTF16LE);
        send_byte(8'h00, 1'b0); send_byte(8'hD8, 1'b1);

        // Unused encoding value flags every byte.
        write_mode(utfd_pkg::MODE_RESERVED);
        send_byte(8'hFF, 1'b0);

        // Random part in three idling regimes, each over the three encodings.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 10; recv_stall_pct = 49; end
                1: begin send_idle_pct = 49; recv_stall_pct = 10; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int m = 0; m < 3; m++)
            begin
                write_mode(utfd_pkg::mode_t'(m));
                // The receiver stops for a long stretch so the decoder backs up.
                if (phase == 0 && m == 0)
                    hold_req = 1'b1;
                run_random(BLOCK_BEATS);
            end
        end
        write_mode(utfd_pkg::MODE_RESERVED);
        run_random(20);
        write_mode(utfd_pkg::MODE_UTF8);
        run_random(20);

        // Drain and let the pipe settle before the verdict.
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
